>>> rtl/byte_stuffed_frame_receiver_defines.svh
// assertion macros for the byte stuffed frame receiver
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsfr assertion failed");

// next-cycle implication, checked out of reset
`define BSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsfr assertion failed");

`endif

>>> rtl/bsfr_pkg.sv
// shared constants, codes and types of the byte stuffed frame receiver
package bsfr_pkg;

    localparam int NUM_BUFFERS = 2;
    localparam int MAX_PAYLOAD = 256;

    localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
    localparam int DEPTH  = NUM_BUFFERS * MAX_PAYLOAD;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ACT_RECV    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_START  = 2'd0,
        CFG_END    = 2'd1,
        CFG_ESCAPE = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'b001,
        MODE_DATA = 3'b010,
        MODE_ESC  = 3'b100
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              accepted;
        logic              frame_done;
        logic [BUF_W-1:0]  done_buffer;
        logic [FILL_W-1:0] done_length;
        logic              overflowed;
        logic              rd_valid;
    } t_result;

endpackage

>>> rtl/bsfr_ram.sv
// generic simple dual port ram with registered read
module bsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bsfr_parser.sv
// deframing control: parse mode, buffer rotation, locks, fill count and store access
module bsfr_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [1:0]                 i_action,
    input  logic [7:0]                 i_line_byte,
    input  logic                       i_buffer_sel,
    input  logic [7:0]                 i_read_offset,
    input  logic                       i_cfg_valid,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output bsfr_pkg::t_ram_req         o_ram_req,
    output bsfr_pkg::t_result          o_result
);

    logic [7:0]                          r_start;
    logic [7:0]                          r_end;
    logic [7:0]                          r_escape;
    bsfr_pkg::t_mode                     r_mode, n_mode;
    logic [bsfr_pkg::BUF_W-1:0]          r_wbuf, n_wbuf;
    logic [bsfr_pkg::NUM_BUFFERS-1:0]    r_lock, n_lock;
    logic [bsfr_pkg::FILL_W-1:0]         r_fill, n_fill;
    logic                                r_lost, n_lost;

    logic                                store;
    logic                                open;
    logic                                sel_ok;
    logic [bsfr_pkg::BUF_W-1:0]          sel;
    bsfr_pkg::t_ram_req                  req;
    bsfr_pkg::t_result                   res;

    assign sel    = bsfr_pkg::BUF_W'(i_buffer_sel);
    assign sel_ok = (int'(sel) < bsfr_pkg::NUM_BUFFERS);

    always_comb begin
        n_mode = r_mode;
        n_wbuf = r_wbuf;
        n_lock = r_lock;
        n_fill = r_fill;
        n_lost = r_lost;
        store  = 1'b0;
        open   = 1'b0;
        req    = '0;
        res    = '0;
        req.raddr = bsfr_pkg::ADDR_W'(sel) * bsfr_pkg::ADDR_W'(bsfr_pkg::MAX_PAYLOAD)
                  + bsfr_pkg::ADDR_W'(i_read_offset);
        req.wdata = i_line_byte;
        req.waddr = bsfr_pkg::ADDR_W'(r_wbuf) * bsfr_pkg::ADDR_W'(bsfr_pkg::MAX_PAYLOAD)
                  + bsfr_pkg::ADDR_W'(r_fill);
        if (i_take) begin
            case (bsfr_pkg::t_action'(i_action))
                bsfr_pkg::ACT_RECV: begin
                    if (!r_lock[r_wbuf]) begin
                        res.accepted = 1'b1;
                        case (r_mode)
                            bsfr_pkg::MODE_WAIT: begin
                                open = (i_line_byte == r_start);
                            end
                            bsfr_pkg::MODE_ESC: begin
                                store  = 1'b1;
                                n_mode = bsfr_pkg::MODE_DATA;
                            end
                            bsfr_pkg::MODE_DATA: begin
                                // end wins over start, start over escape
                                if (i_line_byte == r_end) begin
                                    n_lock[r_wbuf]  = 1'b1;
                                    res.frame_done  = 1'b1;
                                    res.done_buffer = r_wbuf;
                                    res.done_length = r_fill;
                                    res.overflowed  = r_lost;
                                    n_wbuf = (int'(r_wbuf) == bsfr_pkg::NUM_BUFFERS - 1)
                                           ? '0 : r_wbuf + 1'b1;
                                    n_mode = bsfr_pkg::MODE_WAIT;
                                end else if (i_line_byte == r_start) begin
                                    open = 1'b1;
                                end else if (i_line_byte == r_escape) begin
                                    n_mode = bsfr_pkg::MODE_ESC;
                                end else begin
                                    store = 1'b1;
                                end
                            end
                            default: begin
                                n_mode = bsfr_pkg::MODE_WAIT;
                            end
                        endcase
                    end
                end
                bsfr_pkg::ACT_READ: begin
                    req.re       = 1'b1;
                    res.rd_valid = sel_ok &&
                                   (int'(i_read_offset) < bsfr_pkg::MAX_PAYLOAD);
                end
                bsfr_pkg::ACT_RELEASE: begin
                    if (sel_ok) begin
                        n_lock[sel] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (open) begin
            n_fill = '0;
            n_lost = 1'b0;
            n_mode = bsfr_pkg::MODE_DATA;
        end
        if (store) begin
            // past capacity the byte is dropped and the frame marked
            if (int'(r_fill) < bsfr_pkg::MAX_PAYLOAD) begin
                req.we = 1'b1;
                n_fill = r_fill + 1'b1;
            end else begin
                n_lost = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 8'd126;
            r_end    <= 8'd127;
            r_escape <= 8'd125;
            r_mode   <= bsfr_pkg::MODE_WAIT;
            r_wbuf   <= '0;
            r_lock   <= '0;
            r_fill   <= '0;
            r_lost   <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_wbuf <= n_wbuf;
            r_lock <= n_lock;
            r_fill <= n_fill;
            r_lost <= n_lost;
            if (i_cfg_valid) begin
                case (bsfr_pkg::t_cfg_index'(i_cfg_index))
                    bsfr_pkg::CFG_START:  r_start  <= i_cfg_data;
                    bsfr_pkg::CFG_END:    r_end    <= i_cfg_data;
                    bsfr_pkg::CFG_ESCAPE: r_escape <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_ram_req = req;
    assign o_result  = res;

endmodule

>>> rtl/bsfr_outstage.sv
// store read stage and output register with flow control
module bsfr_outstage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  bsfr_pkg::t_result   i_result,
    input  logic [7:0]          i_ram_rdata,
    input  logic                i_out_stall,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bsfr_pkg::t_result   o_result,
    output logic [7:0]          o_read_data
);

    logic                r_s1_valid;
    bsfr_pkg::t_result   r_s1;
    logic                r_out_valid;
    bsfr_pkg::t_result   r_out;
    logic [7:0]          r_out_rdata;
    logic                s1_move;

    // ram read data holds until the next read, which only comes with s1 moving or empty
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_result;
        end
        if (s1_move) begin
            r_out       <= r_s1;
            r_out_rdata <= r_s1.rd_valid ? i_ram_rdata : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_read_data = r_out_rdata;

endmodule

>>> rtl/byte_stuffed_frame_receiver.sv
// byte stuffed frame receiver top level
// Input channel: one beat per action (receive line byte, read stored byte,
// release buffer), qualified by i_in_valid and held off by o_in_stall.
// Output channel: exactly one result beat per input beat, in order, on
// o_out_valid with i_out_stall from the receiver.
// Config channel: i_cfg_valid / o_cfg_ready with a register index
// (0 start byte, 1 end byte, 2 escape byte) and 8-bit data; always ready.
// The user must write it only while the block is idle; the block does not enforce this.
// Each result passes through the read stage and the output register; throughput
// is one beat per cycle while the receiver does not stall, set by the single access
// to the payload ram per beat (a byte write or a byte read) and the registered control update.
// Reset (synchronous, active low) returns the parser to waiting for a start
// byte, buffer 0, all buffers unlocked and configuration to 126/127/125;
// payload ram contents stay undefined until written.
// When the receiver stalls the result is held in the output register and one
// more beat is taken into the read stage; after that o_in_stall rises.
`include "byte_stuffed_frame_receiver_defines.svh"

module byte_stuffed_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_line_byte,
    input  logic       i_buffer_sel,
    input  logic [7:0] i_read_offset,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_accepted,
    output logic       o_frame_done,
    output logic       o_done_buffer,
    output logic [8:0] o_done_length,
    output logic       o_overflowed,
    output logic [7:0] o_read_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic                take;
    bsfr_pkg::t_ram_req  ram_req;
    bsfr_pkg::t_result   res_in;
    bsfr_pkg::t_result   res_out;
    logic [7:0]          ram_rdata;

    assign take        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    bsfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_action      (i_action),
        .i_line_byte   (i_line_byte),
        .i_buffer_sel  (i_buffer_sel),
        .i_read_offset (i_read_offset),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_ram_req     (ram_req),
        .o_result      (res_in)
    );

    bsfr_ram #(
        .WIDTH (bsfr_pkg::BYTE_W),
        .DEPTH (bsfr_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    bsfr_outstage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_result    (res_in),
        .i_ram_rdata (ram_rdata),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (res_out),
        .o_read_data (o_read_data)
    );

    assign o_accepted    = res_out.accepted;
    assign o_frame_done  = res_out.frame_done;
    assign o_done_buffer = res_out.done_buffer[0];
    assign o_done_length = res_out.done_length;
    assign o_overflowed  = res_out.overflowed;

    `BSFR_ASSERT_IMPL(a_done_needs_accept, i_clk, i_rst_n, o_out_valid && o_frame_done, o_accepted)
    `BSFR_ASSERT_IMPL(a_read_excludes_recv, i_clk, i_rst_n, o_out_valid && (o_read_data != 8'd0), !o_accepted && !o_frame_done)
    `BSFR_ASSERT_IMPL(a_room_no_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall)
    `BSFR_ASSERT_IMPL(a_length_bound, i_clk, i_rst_n, o_out_valid && o_frame_done, int'(o_done_length) <= bsfr_pkg::MAX_PAYLOAD)
    `BSFR_ASSERT_NEXT(a_stall_holds_out, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

>>> tb/byte_stuffed_frame_receiver_tb.sv
// self-checking testbench: random framed byte streams, reads and releases against a deframer model
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_tb;

    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 250000;

    typedef struct packed {
        logic       accepted;
        logic       frame_done;
        logic       done_buffer;
        logic [8:0] done_length;
        logic       overflowed;
        logic [7:0] read_data;
    } t_frame_result;

    class t_deframe_checker;
        logic [7:0]      start_code = 8'd126;
        logic [7:0]      end_code = 8'd127;
        logic [7:0]      esc_code = 8'd125;
        bsfr_pkg::t_mode mode = bsfr_pkg::MODE_WAIT;
        int              wr_buf = 0;
        bit              locked [bsfr_pkg::NUM_BUFFERS];
        int              fill = 0;
        bit              lost = 1'b0;
        logic [7:0]      payload [bsfr_pkg::NUM_BUFFERS][bsfr_pkg::MAX_PAYLOAD];
        int              filled_to [bsfr_pkg::NUM_BUFFERS];
        t_frame_result   awaited [$];
        int              mismatches = 0;

        function void set_reg(bsfr_pkg::t_cfg_index idx, logic [7:0] v);
            case (idx)
                bsfr_pkg::CFG_START: start_code = v;
                bsfr_pkg::CFG_END: end_code = v;
                bsfr_pkg::CFG_ESCAPE: esc_code = v;
                default: ;
            endcase
        endfunction

        function void open_frame();
            fill = 0;
            lost = 1'b0;
            mode = bsfr_pkg::MODE_DATA;
        endfunction

        function void keep_byte(logic [7:0] b);
            if (fill < bsfr_pkg::MAX_PAYLOAD) begin
                payload[wr_buf][fill] = b;
                fill++;
                if (fill > filled_to[wr_buf]) filled_to[wr_buf] = fill;
            end else begin
                lost = 1'b1;
            end
        endfunction

        // note one accepted input beat and queue the result it must produce
        function void take_beat(bsfr_pkg::t_action act, logic [7:0] b, logic sel,
                                logic [7:0] off);
            t_frame_result r;
            r = '0;
            case (act)
                bsfr_pkg::ACT_RECV: begin
                    if (!locked[wr_buf]) begin
                        r.accepted = 1'b1;
                        case (mode)
                            bsfr_pkg::MODE_WAIT: begin
                                if (b == start_code) open_frame();
                            end
                            bsfr_pkg::MODE_ESC: begin
                                keep_byte(b);
                                mode = bsfr_pkg::MODE_DATA;
                            end
                            default: begin
                                // end code wins over start, start over escape
                                if (b == end_code) begin
                                    locked[wr_buf] = 1'b1;
                                    r.frame_done = 1'b1;
                                    r.done_buffer = wr_buf[0];
                                    r.done_length = 9'(fill);
                                    r.overflowed = lost;
                                    wr_buf = (wr_buf + 1) % bsfr_pkg::NUM_BUFFERS;
                                    mode = bsfr_pkg::MODE_WAIT;
                                end else if (b == start_code) begin
                                    open_frame();
                                end else if (b == esc_code) begin
                                    mode = bsfr_pkg::MODE_ESC;
                                end else begin
                                    keep_byte(b);
                                end
                            end
                        endcase
                    end
                end
                bsfr_pkg::ACT_READ: r.read_data = payload[sel][off];
                bsfr_pkg::ACT_RELEASE: locked[sel] = 1'b0;
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void report(string what, t_frame_result want, t_frame_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: want acc %0d done %0d buffer %0d len %0d ovf %0d data %02h",
                         what, want.accepted, want.frame_done, want.done_buffer,
                         want.done_length, want.overflowed, want.read_data);
                $display("    got acc %0d done %0d buffer %0d len %0d ovf %0d data %02h",
                         got.accepted, got.frame_done, got.done_buffer,
                         got.done_length, got.overflowed, got.read_data);
            end
        endfunction

        function void match_result(t_frame_result got);
            t_frame_result want;
            if (awaited.size() == 0) begin
                report("result beat with nothing awaited", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.accepted !== want.accepted || got.frame_done !== want.frame_done ||
                got.done_buffer !== want.done_buffer || got.done_length !== want.done_length ||
                got.overflowed !== want.overflowed || got.read_data !== want.read_data)
                report("result mismatch", want, got);
        endfunction

        function void flush();
            while (awaited.size() != 0)
                report("result never arrived", awaited.pop_front(), '0);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] in_action = bsfr_pkg::ACT_NONE;
    logic [7:0] in_byte = 8'h00;
    logic       in_sel = 1'b0;
    logic [7:0] in_off = 8'h00;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = bsfr_pkg::CFG_START;
    logic [7:0] cfg_data = 8'h00;

    logic       in_stall;
    logic       out_valid;
    logic       res_accepted;
    logic       res_done;
    logic       res_buffer;
    logic [8:0] res_length;
    logic       res_overflowed;
    logic [7:0] res_data;
    logic       cfg_ready;

    t_deframe_checker chk = new;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int beats_sent = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    byte_stuffed_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (in_action),
        .i_line_byte   (in_byte),
        .i_buffer_sel  (in_sel),
        .i_read_offset (in_off),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_accepted    (res_accepted),
        .o_frame_done  (res_done),
        .o_done_buffer (res_buffer),
        .o_done_length (res_length),
        .o_overflowed  (res_overflowed),
        .o_read_data   (res_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    task automatic send_beat(bsfr_pkg::t_action act, logic [7:0] b, logic sel,
                             logic [7:0] off);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_byte <= b;
        in_sel <= sel;
        in_off <= off;
        do @(posedge i_clk); while (in_stall);
        chk.take_beat(act, b, sel, off);
        if (act != bsfr_pkg::ACT_NONE) beats_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_beat(bsfr_pkg::ACT_RECV, b, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic release_beat(int sel);
        send_beat(bsfr_pkg::ACT_RELEASE, 8'($urandom), sel[0], 8'($urandom));
    endtask

    // reads only land on entries that some frame has already written
    task automatic read_any();
        int sel;
        if (chk.filled_to[0] == 0 && chk.filled_to[1] == 0) return;
        do sel = $urandom_range(0, bsfr_pkg::NUM_BUFFERS - 1); while (chk.filled_to[sel] == 0);
        send_beat(bsfr_pkg::ACT_READ, 8'($urandom), sel[0],
                  8'($urandom_range(0, chk.filled_to[sel] - 1)));
    endtask

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 2))
            0: return chk.start_code;
            1: return chk.end_code;
            default: return chk.esc_code;
        endcase
    endfunction

    task automatic send_frame(int n, bit close);
        logic [7:0] b;
        send_byte(chk.start_code);
        repeat (n) begin
            b = ($urandom_range(0, 6) == 0) ? special_byte() : 8'($urandom);
            if (b == chk.start_code || b == chk.end_code || b == chk.esc_code)
                send_byte(chk.esc_code);
            send_byte(b);
        end
        if (close) send_byte(chk.end_code);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (chk.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(bsfr_pkg::t_cfg_index idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        chk.set_reg(idx, v);
    endtask

    task automatic set_codes(logic [7:0] s, logic [7:0] e, logic [7:0] x);
        cfg_beat(bsfr_pkg::CFG_START, s);
        cfg_beat(bsfr_pkg::CFG_END, e);
        cfg_beat(bsfr_pkg::CFG_ESCAPE, x);
        cfg_beat(bsfr_pkg::CFG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int budget);
        int stop_at;
        int pick;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (chk.locked[chk.wr_buf] && $urandom_range(0, 4) != 0)
                    release_beat(chk.wr_buf);
                send_frame($urandom_range(0, 12), 1'b1);
                if ($urandom_range(0, 1) == 1) read_any();
            end else if (pick < 67) begin
                read_any();
            end else if (pick < 79) begin
                release_beat($urandom_range(0, 1));
            end else if (pick < 89) begin
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(0, 2) == 0) ? special_byte() : 8'($urandom));
            end else if (pick < 97) begin
                // broken frames: restart mid-frame, escaped end code, or no end at all
                case ($urandom_range(0, 2))
                    0: begin
                        send_frame($urandom_range(1, 6), 1'b0);
                        send_frame($urandom_range(0, 6), 1'b1);
                    end
                    1: begin
                        send_frame($urandom_range(0, 4), 1'b0);
                        send_byte(chk.esc_code);
                        send_byte(chk.end_code);
                    end
                    default: send_frame($urandom_range(0, 6), 1'b0);
                endcase
            end else begin
                send_beat(bsfr_pkg::ACT_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                          8'($urandom));
            end
        end
    endtask

    task automatic run_phase(logic [7:0] s, logic [7:0] e, logic [7:0] x, bit idle,
                             bit squeeze, int budget);
        wait_idle();
        set_codes(s, e, x);
        idle_on = idle;
        hold_req = squeeze;
        run_random(budget);
    endtask

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int hold;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                hold = idle_on ? $urandom_range(0, 9) : 0;
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge i_clk); while (!(out_valid && !out_stall));
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            chk.match_result({res_accepted, res_done, res_buffer, res_length,
                              res_overflowed, res_data});
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed part on the reset codes 7e / 7f / 7d
        send_beat(bsfr_pkg::ACT_NONE, 8'hFF, 1'b1, 8'hFF);
        send_byte(8'h00);                       // ignored outside a frame
        send_byte(8'd126);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'd125);
        send_byte(8'd127);                      // escaped end code is payload
        send_byte(8'd126);                      // restart in the same buffer
        send_byte(8'h55);
        send_byte(8'd127);
        send_beat(bsfr_pkg::ACT_READ, 8'h00, 1'b0, 8'h00);
        release_beat(1);                        // releasing an unlocked buffer
        send_byte(8'd126);
        send_byte(8'd127);                      // empty frame, both buffers locked now
        send_byte(8'd126);                      // dropped
        release_beat(0);
        send_byte(8'd126);
        send_byte(8'd125);
        send_byte(8'd125);
        send_byte(8'd127);
        release_beat(1);
        release_beat(0);
        send_frame(bsfr_pkg::MAX_PAYLOAD, 1'b1);   // exactly full
        repeat (8) read_any();
        run_random(200);

        run_phase(8'h00, 8'hFF, 8'h80, 1'b1, 1'b0, 140);
        run_phase(8'hFF, 8'h00, 8'h01, 1'b1, 1'b1, 140);
        run_phase(8'h5A, 8'h5A, 8'h5A, 1'b0, 1'b0, 140);
        run_phase(8'h10, 8'h20, 8'h20, 1'b1, 1'b0, 140);
        run_phase(8'h30, 8'h31, 8'h30, 1'b1, 1'b0, 140);
        run_phase(8'h01, 8'hFE, 8'hFF, 1'b1, 1'b0, 140);
        run_phase(8'd126, 8'd127, 8'd125, 1'b1, 1'b0, 140);

        // one frame past capacity
        release_beat(chk.wr_buf);
        send_frame(bsfr_pkg::MAX_PAYLOAD + $urandom_range(1, 12), 1'b1);
        repeat (8) read_any();

        wait_idle();
        repeat (4) @(posedge i_clk);
        chk.flush();
        if (chk.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
